// ===== sv/circ_pkg.sv =====
// Shared constants and helpers for the circumcircle unit.
// No dependencies; used by the top level and its port checker.
package circ_pkg;

    localparam int K_WIDTH = 64;

    function automatic int byte_ceil(input int n);
        return ((n + 7) / 8) * 8;
    endfunction

endpackage

// ===== sv/circumcircle_from_three_points_unit.sv =====
// Circumcircle of three fixed-point points: center, radius and constant term.
// Depends on circ_pkg and circ_div.
//
// Usage:
//   The slave channel takes one request per cycle: ax, ay, bx, by_coord, cx, cy
//   packed in s_tdata, each COORD_WIDTH bits signed. The master channel returns
//   center_x, center_y, radius, const_term, degenerate and overflow in m_tdata.
//   The pipeline has six front stages, a divider with one stage per numerator
//   bit (3*COORD_WIDTH+3) plus rounding, four product and sum stages, a square
//   root with one stage per root bit (COORD_WIDTH+1), rounding and the output
//   register.
//   Throughput is one request per cycle; the pipeline advances whenever the
//   output register is empty or taken.
//   When m_tready is low with a result waiting, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits; data in flight is dropped.
//   Collinear points give degenerate set and all other fields zero.
module circumcircle_from_three_points_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // ax, ay, bx, by_coord, cx, cy
    input  logic [circ_pkg::byte_ceil(6*COORD_WIDTH)-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // center_x, center_y, radius, const_term, degenerate, overflow
    output logic [circ_pkg::byte_ceil(3*COORD_WIDTH+circ_pkg::K_WIDTH+2)-1:0] m_tdata
);
    import circ_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;
    localparam int PW   = 2 * DW;
    localparam int DETW = 2 * W + 4;
    localparam int SW   = 2 * W + 2;
    localparam int HW   = W + 1;
    localparam int MW   = 2 * W + 3;
    localparam int NW   = 3 * W + 4;
    localparam int NM   = 3 * W + 3;
    localparam int DM   = 2 * W + 3;
    localparam int SX   = NW + 1;
    localparam int KW   = 4 * W + 7;
    localparam int RW   = W + 1;
    localparam int EW   = SW;
    localparam int PLD  = 6 * W + 1;
    localparam int PLS  = 2 * W + K_WIDTH + 3;
    localparam int LAT  = 4 * W + 17;
    localparam int OTW  = byte_ceil(3 * W + K_WIDTH + 2);

    logic           en;
    logic [LAT-1:0] vld_reg;

    assign m_tvalid = vld_reg[LAT-1];
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // front: differences relative to the first point
    logic signed [W-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
    assign in_ax = s_tdata[W-1:0];
    assign in_ay = s_tdata[2*W-1:W];
    assign in_bx = s_tdata[3*W-1:2*W];
    assign in_by = s_tdata[4*W-1:3*W];
    assign in_cx = s_tdata[5*W-1:4*W];
    assign in_cy = s_tdata[6*W-1:5*W];

    logic signed [W-1:0]  ax1_reg, ay1_reg;
    logic signed [DW-1:0] bx1_reg, by1_reg, cx1_reg, cy1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ax1_reg <= in_ax;
            ay1_reg <= in_ay;
            bx1_reg <= DW'(in_bx) - DW'(in_ax);
            by1_reg <= DW'(in_by) - DW'(in_ay);
            cx1_reg <= DW'(in_cx) - DW'(in_ax);
            cy1_reg <= DW'(in_cy) - DW'(in_ay);
        end
    end

    // stage 2: first products
    logic signed [W-1:0]   ax2_reg, ay2_reg;
    logic signed [DW-1:0]  bx2_reg, by2_reg, cx2_reg, cy2_reg;
    logic signed [PW-1:0]  bxcy2_reg, bycx2_reg, bxbx2_reg, byby2_reg, cxcx2_reg, cycy2_reg;
    logic signed [2*W-1:0] axsq2_reg, aysq2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            bx2_reg   <= bx1_reg;
            by2_reg   <= by1_reg;
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;
            bxcy2_reg <= bx1_reg * cy1_reg;
            bycx2_reg <= by1_reg * cx1_reg;
            bxbx2_reg <= bx1_reg * bx1_reg;
            byby2_reg <= by1_reg * by1_reg;
            cxcx2_reg <= cx1_reg * cx1_reg;
            cycy2_reg <= cy1_reg * cy1_reg;
            axsq2_reg <= ax1_reg * ax1_reg;
            aysq2_reg <= ay1_reg * ay1_reg;
        end
    end

    // stage 3: determinant and squared lengths
    logic signed [W-1:0]   ax3_reg, ay3_reg;
    logic signed [DW-1:0]  bx3_reg, by3_reg, cx3_reg, cy3_reg;
    logic signed [2*W-1:0] axsq3_reg, aysq3_reg;
    logic signed [DETW-1:0] det3_reg;
    logic [SW-1:0]         sb3_reg, sc3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
            bx3_reg   <= bx2_reg;
            by3_reg   <= by2_reg;
            cx3_reg   <= cx2_reg;
            cy3_reg   <= cy2_reg;
            axsq3_reg <= axsq2_reg;
            aysq3_reg <= aysq2_reg;
            det3_reg  <= (DETW'(bxcy2_reg) - DETW'(bycx2_reg)) <<< 1;
            sb3_reg   <= $unsigned(bxbx2_reg) + $unsigned(byby2_reg);
            sc3_reg   <= $unsigned(cxcx2_reg) + $unsigned(cycy2_reg);
        end
    end

    // stage 4: numerator partial products
    logic signed [HW:0] sbl, sbh, scl, sch;
    assign sbl = $signed({1'b0, sb3_reg[HW-1:0]});
    assign sbh = $signed({1'b0, sb3_reg[SW-1:HW]});
    assign scl = $signed({1'b0, sc3_reg[HW-1:0]});
    assign sch = $signed({1'b0, sc3_reg[SW-1:HW]});

    logic signed [W-1:0]   ax4_reg, ay4_reg;
    logic signed [2*W-1:0] axsq4_reg, aysq4_reg;
    logic signed [MW-1:0]  cysbl4_reg, cysbh4_reg, byscl4_reg, bysch4_reg;
    logic signed [MW-1:0]  bxscl4_reg, bxsch4_reg, cxsbl4_reg, cxsbh4_reg;
    logic [DM-1:0]         dabs4_reg;
    logic                  dneg4_reg, degen4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ax4_reg    <= ax3_reg;
            ay4_reg    <= ay3_reg;
            axsq4_reg  <= axsq3_reg;
            aysq4_reg  <= aysq3_reg;
            cysbl4_reg <= cy3_reg * sbl;
            cysbh4_reg <= cy3_reg * sbh;
            byscl4_reg <= by3_reg * scl;
            bysch4_reg <= by3_reg * sch;
            bxscl4_reg <= bx3_reg * scl;
            bxsch4_reg <= bx3_reg * sch;
            cxsbl4_reg <= cx3_reg * sbl;
            cxsbh4_reg <= cx3_reg * sbh;
            degen4_reg <= (det3_reg == '0);
            dneg4_reg  <= det3_reg[DETW-1];
            dabs4_reg  <= det3_reg[DETW-1] ? DM'(-det3_reg) : DM'(det3_reg);
        end
    end

    // stage 5: numerators
    logic signed [W-1:0]   ax5_reg, ay5_reg;
    logic signed [2*W-1:0] axsq5_reg, aysq5_reg;
    logic signed [NW-1:0]  numx5_reg, numy5_reg;
    logic [DM-1:0]         dabs5_reg;
    logic                  dneg5_reg, degen5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ax5_reg    <= ax4_reg;
            ay5_reg    <= ay4_reg;
            axsq5_reg  <= axsq4_reg;
            aysq5_reg  <= aysq4_reg;
            dabs5_reg  <= dabs4_reg;
            dneg5_reg  <= dneg4_reg;
            degen5_reg <= degen4_reg;
            numx5_reg  <= (NW'(cysbh4_reg) <<< HW) + NW'(cysbl4_reg)
                        - (NW'(bysch4_reg) <<< HW) - NW'(byscl4_reg);
            numy5_reg  <= (NW'(bxsch4_reg) <<< HW) + NW'(bxscl4_reg)
                        - (NW'(cxsbh4_reg) <<< HW) - NW'(cxsbl4_reg);
        end
    end

    // stage 6: magnitudes and quotient signs
    logic [PLD-1:0] pl6_reg;
    logic [NM-1:0]  nxabs6_reg, nyabs6_reg;
    logic [DM-1:0]  dabs6_reg;
    logic           negx6_reg, negy6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pl6_reg    <= {degen5_reg, aysq5_reg, axsq5_reg, ay5_reg, ax5_reg};
            dabs6_reg  <= dabs5_reg;
            nxabs6_reg <= numx5_reg[NW-1] ? NM'(-numx5_reg) : NM'(numx5_reg);
            nyabs6_reg <= numy5_reg[NW-1] ? NM'(-numy5_reg) : NM'(numy5_reg);
            negx6_reg  <= numx5_reg[NW-1] ^ dneg5_reg;
            negy6_reg  <= numy5_reg[NW-1] ^ dneg5_reg;
        end
    end

    // dividers and matching payload line
    logic signed [NW-1:0] ux_q, uy_q;

    circ_div #(.NUM_W(NM), .DEN_W(DM)) u_div_x (
        .aclk  (aclk),
        .en    (en),
        .num_i (nxabs6_reg),
        .den_i (dabs6_reg),
        .neg_i (negx6_reg),
        .quo_o (ux_q)
    );

    circ_div #(.NUM_W(NM), .DEN_W(DM)) u_div_y (
        .aclk  (aclk),
        .en    (en),
        .num_i (nyabs6_reg),
        .den_i (dabs6_reg),
        .neg_i (negy6_reg),
        .quo_o (uy_q)
    );

    logic [PLD-1:0] dl_reg [0:NM];

    always_ff @(posedge aclk) begin
        if (en) begin
            dl_reg[0] <= pl6_reg;
            for (int i = 1; i <= NM; i++) begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    logic signed [W-1:0]   ax_d, ay_d;
    logic signed [2*W-1:0] axsq_d, aysq_d;
    logic                  degen_d;
    assign ax_d    = dl_reg[NM][W-1:0];
    assign ay_d    = dl_reg[NM][2*W-1:W];
    assign axsq_d  = dl_reg[NM][4*W-1:2*W];
    assign aysq_d  = dl_reg[NM][6*W-1:4*W];
    assign degen_d = dl_reg[NM][6*W];

    // stage 7: center clamp, range test, offset products
    logic signed [SX-1:0] sumx, sumy, cmax, cmin;
    logic signed [NW-1:0] ubig;
    logic signed [W-1:0]  cxc, cyc;
    logic                 ovc, bigu;
    logic signed [DW-1:0] uxs, uys;
    logic signed [W:0]    uxl, uxm, uyl, uym;
    logic signed [W+3:0]  uxh, uyh;

    always_comb begin
        cmax = $signed({{(SX-W+1){1'b0}}, {(W-1){1'b1}}});
        cmin = ~cmax;
        ubig = $signed({{(NW-W){1'b0}}, {W{1'b1}}});
        sumx = SX'(ax_d) + SX'(ux_q);
        sumy = SX'(ay_d) + SX'(uy_q);
        ovc  = 1'b0;
        if (sumx > cmax) begin
            cxc = cmax[W-1:0];
            ovc = 1'b1;
        end else if (sumx < cmin) begin
            cxc = cmin[W-1:0];
            ovc = 1'b1;
        end else begin
            cxc = sumx[W-1:0];
        end
        if (sumy > cmax) begin
            cyc = cmax[W-1:0];
            ovc = 1'b1;
        end else if (sumy < cmin) begin
            cyc = cmin[W-1:0];
            ovc = 1'b1;
        end else begin
            cyc = sumy[W-1:0];
        end
        bigu = (ux_q > ubig) || (ux_q < -ubig) || (uy_q > ubig) || (uy_q < -ubig);
        uxs  = $signed(ux_q[DW-1:0]);
        uys  = $signed(uy_q[DW-1:0]);
        uxl  = $signed({1'b0, ux_q[W-1:0]});
        uxm  = $signed({1'b0, ux_q[2*W-1:W]});
        uxh  = $signed(ux_q[NW-1:2*W]);
        uyl  = $signed({1'b0, uy_q[W-1:0]});
        uym  = $signed({1'b0, uy_q[2*W-1:W]});
        uyh  = $signed(uy_q[NW-1:2*W]);
    end

    logic signed [W-1:0]   cx7_reg, cy7_reg;
    logic                  ov7_reg, big7_reg, degen7_reg;
    logic signed [2*W-1:0] axsq7_reg, aysq7_reg;
    logic signed [PW-1:0]  uxsq7_reg, uysq7_reg;
    logic signed [2*W:0]   axl7_reg, axm7_reg, ayl7_reg, aym7_reg;
    logic signed [2*W+3:0] axh7_reg, ayh7_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cx7_reg    <= cxc;
            cy7_reg    <= cyc;
            ov7_reg    <= ovc;
            big7_reg   <= bigu;
            degen7_reg <= degen_d;
            axsq7_reg  <= axsq_d;
            aysq7_reg  <= aysq_d;
            uxsq7_reg  <= uxs * uxs;
            uysq7_reg  <= uys * uys;
            axl7_reg   <= ax_d * uxl;
            axm7_reg   <= ax_d * uxm;
            axh7_reg   <= ax_d * uxh;
            ayl7_reg   <= ay_d * uyl;
            aym7_reg   <= ay_d * uym;
            ayh7_reg   <= ay_d * uyh;
        end
    end

    // stage 8: squared radius, full offset products
    logic signed [W-1:0]   cx8_reg, cy8_reg;
    logic                  ov8_reg, big8_reg, degen8_reg;
    logic signed [2*W-1:0] axsq8_reg, aysq8_reg;
    logic [SW-1:0]         s8_reg;
    logic signed [KW-1:0]  axux8_reg, ayuy8_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cx8_reg    <= cx7_reg;
            cy8_reg    <= cy7_reg;
            ov8_reg    <= ov7_reg;
            big8_reg   <= big7_reg;
            degen8_reg <= degen7_reg;
            axsq8_reg  <= axsq7_reg;
            aysq8_reg  <= aysq7_reg;
            s8_reg     <= $unsigned(uxsq7_reg) + $unsigned(uysq7_reg);
            axux8_reg  <= (KW'(axh7_reg) <<< (2*W)) + (KW'(axm7_reg) <<< W) + KW'(axl7_reg);
            ayuy8_reg  <= (KW'(ayh7_reg) <<< (2*W)) + (KW'(aym7_reg) <<< W) + KW'(ayl7_reg);
        end
    end

    // stage 9: constant term
    logic signed [W-1:0]  cx9_reg, cy9_reg;
    logic                 ov9_reg, big9_reg, degen9_reg;
    logic [SW-1:0]        s9_reg;
    logic signed [KW-1:0] k9_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cx9_reg    <= cx8_reg;
            cy9_reg    <= cy8_reg;
            ov9_reg    <= ov8_reg;
            big9_reg   <= big8_reg;
            degen9_reg <= degen8_reg;
            s9_reg     <= s8_reg;
            k9_reg     <= KW'(axsq8_reg) + KW'(aysq8_reg) + ((axux8_reg + ayuy8_reg) <<< 1);
        end
    end

    // stage 10: clamp constant term, load square root
    logic signed [KW-1:0]  kmax, kmin;
    logic [K_WIDTH-1:0]    kc;
    logic                  ovk;

    always_comb begin
        kmax = $signed({{(KW-K_WIDTH+1){1'b0}}, {(K_WIDTH-1){1'b1}}});
        kmin = ~kmax;
        ovk  = 1'b0;
        if (k9_reg > kmax) begin
            kc  = kmax[K_WIDTH-1:0];
            ovk = 1'b1;
        end else if (k9_reg < kmin) begin
            kc  = kmin[K_WIDTH-1:0];
            ovk = 1'b1;
        end else begin
            kc = k9_reg[K_WIDTH-1:0];
        end
    end

    logic [EW-1:0]  e_reg  [0:RW];
    logic [RW-1:0]  r_reg  [0:RW];
    logic [PLS-1:0] ps_reg [0:RW];

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg[0]  <= s9_reg;
            r_reg[0]  <= '0;
            ps_reg[0] <= {degen9_reg, big9_reg, ov9_reg | ovk, kc, cy9_reg, cx9_reg};
        end
    end

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        localparam int B = RW - 1 - j;
        logic [EW-1:0] trial;

        assign trial = (EW'(r_reg[j]) << (B + 1)) | (EW'(1) << (2 * B));

        always_ff @(posedge aclk) begin
            if (en) begin
                if (e_reg[j] >= trial) begin
                    e_reg[j+1] <= e_reg[j] - trial;
                    r_reg[j+1] <= r_reg[j] | (RW'(1) << B);
                end else begin
                    e_reg[j+1] <= e_reg[j];
                    r_reg[j+1] <= r_reg[j];
                end
                ps_reg[j+1] <= ps_reg[j];
            end
        end
    end

    // root rounding
    logic [RW:0]    rr_reg;
    logic [PLS-1:0] pr_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rr_reg <= (e_reg[RW] > EW'(r_reg[RW])) ? ((RW+1)'(r_reg[RW]) + 1'b1)
                                                   : (RW+1)'(r_reg[RW]);
            pr_reg <= ps_reg[RW];
        end
    end

    // output register
    logic [W-1:0]       o_cx, o_cy;
    logic [K_WIDTH-1:0] o_k;
    logic               o_ov, o_big, o_degen, rad_sat;
    logic [W-1:0]       o_rad;
    logic [OTW-1:0]     o_data;

    always_comb begin
        o_cx    = pr_reg[W-1:0];
        o_cy    = pr_reg[2*W-1:W];
        o_k     = pr_reg[2*W+K_WIDTH-1:2*W];
        o_ov    = pr_reg[2*W+K_WIDTH];
        o_big   = pr_reg[2*W+K_WIDTH+1];
        o_degen = pr_reg[2*W+K_WIDTH+2];
        rad_sat = o_big || (rr_reg > (RW+1)'({W{1'b1}}));
        o_rad   = rad_sat ? {W{1'b1}} : rr_reg[W-1:0];
        o_data  = '0;
        if (o_degen) begin
            o_data[3*W+K_WIDTH] = 1'b1;
        end else begin
            o_data[3*W+K_WIDTH+1:0] = {o_ov | rad_sat, 1'b0, o_k, o_rad, o_cy, o_cx};
        end
    end

    logic [OTW-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= o_data;
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

// ===== sv/circ_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, round to nearest.
// Stand-alone; instantiated by circumcircle_from_three_points_unit.
module circ_div #(
    parameter int NUM_W = 99,
    parameter int DEN_W = 67
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [NUM_W-1:0]        num_i,
    input  logic [DEN_W-1:0]        den_i,
    input  logic                    neg_i,
    output logic signed [NUM_W:0]   quo_o
);

    logic [NUM_W-1:0] n_reg   [0:NUM_W-1];
    logic [DEN_W-1:0] d_reg   [0:NUM_W-1];
    logic [DEN_W-1:0] rem_reg [0:NUM_W-1];
    logic [NUM_W-1:0] q_reg   [0:NUM_W-1];
    logic             s_reg   [0:NUM_W-1];
    logic signed [NUM_W:0] quo_reg;

    for (genvar j = 0; j < NUM_W; j++) begin : g_stage
        logic [NUM_W-1:0] n_in;
        logic [DEN_W-1:0] d_in;
        logic [DEN_W-1:0] r_in;
        logic [NUM_W-1:0] q_in;
        logic             s_in;
        logic [DEN_W:0]   t;
        logic             ge;

        if (j == 0) begin : g_first
            assign n_in = num_i;
            assign d_in = den_i;
            assign r_in = '0;
            assign q_in = '0;
            assign s_in = neg_i;
        end else begin : g_next
            assign n_in = n_reg[j-1];
            assign d_in = d_reg[j-1];
            assign r_in = rem_reg[j-1];
            assign q_in = q_reg[j-1];
            assign s_in = s_reg[j-1];
        end

        assign t  = {r_in, n_in[NUM_W-1]};
        assign ge = (t >= {1'b0, d_in});

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[j]   <= n_in << 1;
                d_reg[j]   <= d_in;
                s_reg[j]   <= s_in;
                rem_reg[j] <= ge ? DEN_W'(t - {1'b0, d_in}) : t[DEN_W-1:0];
                q_reg[j]   <= {q_in[NUM_W-2:0], ge};
            end
        end
    end

    logic             rnd;
    logic [NUM_W:0]   qr;

    assign rnd = ({rem_reg[NUM_W-1], 1'b0} >= {1'b0, d_reg[NUM_W-1]});
    assign qr  = {1'b0, q_reg[NUM_W-1]} + (NUM_W+1)'(rnd);

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= s_reg[NUM_W-1] ? -$signed(qr) : $signed(qr);
        end
    end

    assign quo_o = quo_reg;

endmodule

// ===== sv/circ_chk.sv =====
// Port checker for circumcircle_from_three_points_unit, bound to the top level.
// Depends on circ_pkg.
module circ_chk #(
    parameter int COORD_WIDTH = 32
) (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    // ax, ay, bx, by_coord, cx, cy
    input logic [circ_pkg::byte_ceil(6*COORD_WIDTH)-1:0] s_tdata,
    input logic m_tvalid,
    input logic m_tready,
    // center_x, center_y, radius, const_term, degenerate, overflow
    input logic [circ_pkg::byte_ceil(3*COORD_WIDTH+circ_pkg::K_WIDTH+2)-1:0] m_tdata
);
    import circ_pkg::*;

    localparam int DEG = 3 * COORD_WIDTH + K_WIDTH;
    localparam int OVF = DEG + 1;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[DEG] |-> m_tdata[DEG-1:0] == '0 && !m_tdata[OVF])
        else $error("degenerate result carries data");

    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##1 !$isunknown(s_tready))
        else $error("ready unknown after request");

endmodule

bind circumcircle_from_three_points_unit circ_chk #(.COORD_WIDTH(COORD_WIDTH)) u_circ_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
